// File: rtl/core/cd_sector_address_translate_top_macros.svh
// Assertion macros shared by the address translation RTL.
`ifndef CD_SECTOR_ADDRESS_TRANSLATE_TOP_MACROS_SVH
`define CD_SECTOR_ADDRESS_TRANSLATE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define CDSAT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define CDSAT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDSAT_ASSERT(lbl, clk, rst, prop, msg)
`define CDSAT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/core/cdsat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cdsat_pkg;

  localparam int MAX_TRACKS          = 128;
  localparam int SOURCE_FILES        = 16;
  localparam int STREAM_SECTOR_BYTES = 2048;

  localparam int SLOT_W   = $clog2(MAX_TRACKS);
  localparam int COUNT_W  = 8;
  localparam int SECT_SH  = $clog2(STREAM_SECTOR_BYTES);
  localparam int ADDR_W   = 35;
  localparam int SECTOR_W = ADDR_W - SECT_SH;
  localparam int CHUNK_W  = 12;
  localparam int LEN_W    = 16;
  localparam int OFF_W    = 48;
  localparam int SRC_W    = 4;
  localparam int SIZE_W   = 12;
  localparam int START_W  = 24;
  localparam int TLEN_W   = 25;
  localparam int PROD_W   = START_W + SIZE_W;

  // Request kinds
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // One table entry as held in the track memory
  typedef struct packed {
    logic               audio;
    logic [SIZE_W-1:0]  data_off;
    logic [SIZE_W-1:0]  sect_size;
    logic [TLEN_W-1:0]  length;
    logic [START_W-1:0] start;
    logic [SRC_W-1:0]   src_id;
    logic [OFF_W-1:0]   base;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Track memory access from the controller
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } ram_req_t;

endpackage
`default_nettype wire

// File: rtl/core/cdsat_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// Request channel: load or lookup transactions.
interface cdsat_req_if import cdsat_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [6:0]         track_index;
  logic [START_W-1:0] start_sector;
  logic [TLEN_W-1:0]  sector_count;
  logic [SIZE_W-1:0]  stored_sector_size;
  logic [SIZE_W-1:0]  user_data_offset;
  logic               audio_track;
  logic [SRC_W-1:0]   source_id;
  logic [OFF_W-1:0]   source_base;
  logic [ADDR_W-1:0]  stream_offset;
  logic [LEN_W-1:0]   request_length;

  modport source (output valid, req_type, track_index, start_sector, sector_count,
                  stored_sector_size, user_data_offset, audio_track, source_id,
                  source_base, stream_offset, request_length, input ready);
  modport sink (input valid, req_type, track_index, start_sector, sector_count,
                stored_sector_size, user_data_offset, audio_track, source_id,
                source_base, stream_offset, request_length, output ready);
endinterface

// Result channel: one transaction per translated chunk.
interface cdsat_res_if import cdsat_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               zero_fill;
  logic [SRC_W-1:0]   out_source_id;
  logic [OFF_W-1:0]   source_offset;
  logic [CHUNK_W-1:0] chunk_length;

  modport source (output valid, zero_fill, out_source_id, source_offset, chunk_length,
                  input ready);
  modport sink (input valid, zero_fill, out_source_id, source_offset, chunk_length,
                output ready);
endinterface
`default_nettype wire

// File: rtl/core/cdsat_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module cdsat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/cdsat_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "cd_sector_address_translate_top_macros.svh"
module cdsat_ctrl import cdsat_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wen,
  input  wire logic [7:0]   cfg_wdata,
  cdsat_req_if.sink         req,
  cdsat_res_if.source       res,
  output ram_req_t          ram_req,
  input  wire entry_t       ram_rdata
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SEARCH  = 6'b000010,
    ST_COMPARE = 6'b000100,
    ST_MULT    = 6'b001000,
    ST_SUM     = 6'b010000,
    ST_RESULT  = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [COUNT_W-1:0]  track_count;
  logic [COUNT_W-1:0]  count_lim;
  logic [COUNT_W-1:0]  lo, hi;
  logic [SLOT_W-1:0]   mid;
  logic [COUNT_W:0]    mid_sum;
  logic [SECTOR_W-1:0] sector;
  logic [SECT_SH-1:0]  sect_off;
  logic [CHUNK_W-1:0]  chunk;
  logic [CHUNK_W-1:0]  chunk_raw;
  logic                zf;
  entry_t              ent;
  logic [PROD_W-1:0]   prod;
  logic [OFF_W-1:0]    off;

  logic                out_valid;
  logic                out_zf;
  logic [SRC_W-1:0]    out_src;
  logic [OFF_W-1:0]    out_off;
  logic [CHUNK_W-1:0]  out_chunk;

  logic                in_fire;
  logic                probe_ok;
  logic                below, above;
  logic [TLEN_W:0]     end_sector;
  logic                out_free;

  // Clamp the table size and form the search midpoint
  assign count_lim = (track_count > COUNT_W'(MAX_TRACKS)) ? COUNT_W'(MAX_TRACKS) : track_count;
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign probe_ok  = (lo < hi);

  assign in_fire   = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);

  // Split the incoming address and cap the chunk at the sector end
  assign chunk_raw = CHUNK_W'(STREAM_SECTOR_BYTES) - CHUNK_W'(req.stream_offset[SECT_SH-1:0]);

  // Compare the sector against the probed entry
  assign end_sector = {1'b0, ram_rdata.length} + (TLEN_W+1)'(ram_rdata.start);
  assign below      = (sector < ram_rdata.start);
  assign above      = ((TLEN_W+1)'(sector) >= end_sector);

  assign out_free = !out_valid || res.ready;

  // Drive the track memory
  always_comb begin
    ram_req.we    = in_fire && (req.req_type == REQ_LOAD);
    ram_req.waddr = req.track_index[SLOT_W-1:0];
    ram_req.wdata = '{audio:     req.audio_track,
                      data_off:  req.user_data_offset,
                      sect_size: req.stored_sector_size,
                      length:    req.sector_count,
                      start:     req.start_sector,
                      src_id:    req.source_id,
                      base:      req.source_base};
    ram_req.re    = (state == ST_SEARCH) && probe_ok;
    ram_req.raddr = mid_sum[SLOT_W:1];
  end

  // Advance the lookup sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && (req.req_type == REQ_LOOKUP) && (req.request_length != '0)) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH:  state_next = probe_ok ? ST_COMPARE : ST_RESULT;
      ST_COMPARE: begin
        if (below || above) begin
          state_next = ST_SEARCH;
        end else if (ram_rdata.audio) begin
          state_next = ST_RESULT;
        end else begin
          state_next = ST_MULT;
        end
      end
      ST_MULT:   state_next = ST_SUM;
      ST_SUM:    state_next = ST_RESULT;
      ST_RESULT: state_next = out_free ? ST_IDLE : ST_RESULT;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Hold control state and the result register flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      track_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        track_count <= cfg_wdata;
      end
      if ((state == ST_RESULT) && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers of the lookup in flight
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        sector   <= req.stream_offset[ADDR_W-1:SECT_SH];
        sect_off <= req.stream_offset[SECT_SH-1:0];
        chunk    <= ((LEN_W)'(chunk_raw) > req.request_length) ?
                    req.request_length[CHUNK_W-1:0] : chunk_raw;
        lo       <= '0;
        hi       <= count_lim;
      end
      ST_SEARCH: begin
        mid <= mid_sum[SLOT_W:1];
        zf  <= 1'b1;
      end
      ST_COMPARE: begin
        ent <= ram_rdata;
        zf  <= ram_rdata.audio;
        if (below) begin
          hi <= COUNT_W'(mid);
        end else if (above) begin
          lo <= COUNT_W'(mid) + COUNT_W'(1);
        end
      end
      ST_MULT: begin
        prod <= PROD_W'(START_W'(sector - ent.start)) * PROD_W'(ent.sect_size);
      end
      ST_SUM: begin
        off <= ent.base + OFF_W'(prod) + OFF_W'(ent.data_off) + OFF_W'(sect_off);
      end
      ST_RESULT: begin
        if (out_free) begin
          out_zf    <= zf;
          out_src   <= zf ? '0 : ent.src_id;
          out_off   <= zf ? '0 : off;
          out_chunk <= chunk;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.valid         = out_valid;
  assign res.zero_fill     = out_zf;
  assign res.out_source_id = out_src;
  assign res.source_offset = out_off;
  assign res.chunk_length  = out_chunk;

  `CDSAT_ASSERT(a_hi_bound, clk, rst, (state == ST_SEARCH) |-> (hi <= count_lim), "search bound above table size")
  `CDSAT_ASSERT(a_mid_range, clk, rst, (state == ST_COMPARE) |-> ((COUNT_W'(mid) >= lo) && (COUNT_W'(mid) < hi)), "probe outside search window")
  `CDSAT_ASSERT(a_start, clk, rst, (in_fire && (req.req_type == REQ_LOOKUP) && (req.request_length != '0)) |=> (state == ST_SEARCH), "lookup did not start a search")
  `CDSAT_ASSERT(a_stall_hold, clk, rst, ((state == ST_RESULT) && out_valid && !res.ready) |=> (state == ST_RESULT), "result overwritten during stall")
  `CDSAT_ASSERT(a_chunk_nz, clk, rst, out_valid |-> (out_chunk != '0), "empty chunk presented")

endmodule
`default_nettype wire

// File: rtl/core/cd_sector_address_translate_top.sv
// CD sector address translation.
// The req channel carries two kinds of transaction. A load writes one track
// entry into the table in the cycle it is accepted; it yields no result. A
// lookup translates a byte address of the flat 2048-byte-sector stream into
// a source file and byte offset, or a zero-fill chunk, with the chunk length
// capped at the sector end. Lookups with a zero length yield no result.
// cfg_wen/cfg_wdata set the number of valid table entries; write it only
// while the block is idle.
// A lookup runs a binary search of at most 8 probes for 128 entries; each
// probe reads the track memory, whose read port is registered, in ST_SEARCH
// and compares in ST_COMPARE. A data track then passes ST_MULT and ST_SUM
// before ST_RESULT; a zero-fill chunk goes straight to ST_RESULT. One lookup
// is in flight at a time, so a new request is taken in the cycle after the
// previous result is registered.
// Loads are taken one per cycle while the block is idle.
// Reset clears the control state and sets the table size to zero; the table
// contents are undefined until loaded. A stalled receiver holds the result
// register; the next lookup proceeds and waits for the register to drain.
`timescale 1ns / 1ps
`default_nettype none
module cd_sector_address_translate_top import cdsat_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wen,
  input  wire logic [7:0] cfg_wdata,
  cdsat_req_if.sink       req,
  cdsat_res_if.source     res
);

  ram_req_t               ram_req;
  logic [ENTRY_W-1:0]     ram_rdata;

  // Sequence lookups and loads
  cdsat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (entry_t'(ram_rdata))
  );

  // Hold the track table
  cdsat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TRACKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire
